FILE: sv/touch_gesture_recognizer_defines.svh
// assertion macros for the touch gesture recognizer
// used by the top level only, expects i_clk and i_rst_n in scope
`ifndef TOUCH_GESTURE_RECOGNIZER_DEFINES_SVH
`define TOUCH_GESTURE_RECOGNIZER_DEFINES_SVH

// same-cycle implication
`define TGR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TGR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tgr_pkg.sv
// shared types, codes and constants of the touch gesture recognizer
// no dependencies
package tgr_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CW = 28;   // cordic x/y width
    localparam int ZW = 20;   // cordic angle width, q.16
    localparam int NW = 27;   // divider numerator width

    localparam logic [2:0] REQ_TAP     = 3'd0;
    localparam logic [2:0] REQ_DRAG    = 3'd1;
    localparam logic [2:0] REQ_RELEASE = 3'd2;
    localparam logic [2:0] REQ_CANCEL  = 3'd3;
    localparam logic [2:0] REQ_TICK    = 3'd4;
    localparam logic [2:0] REQ_MODAL   = 3'd5;

    localparam logic [2:0] G_NONE  = 3'd0;
    localparam logic [2:0] G_CLICK = 3'd1;
    localparam logic [2:0] G_DBL   = 3'd2;
    localparam logic [2:0] G_DRAG  = 3'd3;
    localparam logic [2:0] G_PINCH = 3'd4;
    localparam logic [2:0] G_LONG  = 3'd5;

    localparam int MB_CLICK = 0;
    localparam int MB_DRAG  = 1;
    localparam int MB_PINCH = 2;
    localparam int MB_DBL   = 3;
    localparam int MB_LONG  = 4;

    localparam logic [2:0] REG_MASK   = 3'd0;
    localparam logic [2:0] REG_DBL    = 3'd1;
    localparam logic [2:0] REG_LONG   = 3'd2;
    localparam logic [2:0] REG_THR    = 3'd3;
    localparam logic [2:0] REG_WINDOW = 3'd4;

    localparam logic [7:0]  THR_RST    = 8'd10;
    localparam logic [15:0] WINDOW_RST = 16'd300;

    localparam logic signed [ZW-1:0] PI_Q16     = 20'sd205887;
    localparam logic signed [ZW-1:0] TWO_PI_Q16 = 20'sd411775;
    localparam logic [15:0]          INV_GAIN   = 16'd39797;

    typedef struct packed {
        logic [4:0]  mask;
        logic        dbl;
        logic        lt;
        logic [7:0]  thr;
        logic [15:0] win;
    } t_cfg;

    typedef struct packed {
        logic        is_tap;
        logic        is_drag;
        logic        is_end;
        logic        is_tick;
        logic        is_modal;
        logic [7:0]  id;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] dt;
        logic        busy;
    } t_item;

    typedef struct packed {
        logic [2:0]  gesture;
        logic        used;
        logic        claim;
        logic        rel;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [16:0] move_x;
        logic [16:0] move_y;
        logic [15:0] ratio;
        logic [15:0] rot;
        logic [31:0] held;
        logic        last;
    } t_res;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:    v = 20'sd51472;
            5'd1:    v = 20'sd30386;
            5'd2:    v = 20'sd16055;
            5'd3:    v = 20'sd8150;
            5'd4:    v = 20'sd4091;
            5'd5:    v = 20'sd2047;
            5'd6:    v = 20'sd1024;
            5'd7:    v = 20'sd512;
            5'd8:    v = 20'sd256;
            5'd9:    v = 20'sd128;
            5'd10:   v = 20'sd64;
            5'd11:   v = 20'sd32;
            5'd12:   v = 20'sd16;
            5'd13:   v = 20'sd8;
            5'd14:   v = 20'sd4;
            5'd15:   v = 20'sd2;
            5'd16:   v = 20'sd1;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/touch_gesture_recognizer.sv
// top level of the touch gesture recognizer: register port, front, back
// depends on tgr_pkg, tgr_front, tgr_back, touch_gesture_recognizer_defines.svh
//
// channel    direction  handshake                    payload
// items      in         push / full                  i_req_type .. i_group_busy
// results    out        empty / pop                  o_gesture .. o_last
// registers  in/out     psel penable pwrite pready   paddr pwdata prdata
//
// tap, drag, release, tick and modal items pass through S_EXEC and S_EMIT
// a second tap also runs the cordic unit for the start length and angle
// a pinch report runs the cordic unit, then the divider if the start length is nonzero
// the front queue holds two items, so the input stalls only while both are waiting
// the result queue holds four; an item starts only with room for two results
// reset is synchronous and needs no clearing pass
`include "touch_gesture_recognizer_defines.svh"

module touch_gesture_recognizer #(
    parameter int CORDIC_STEPS = tgr_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_req_type,
    input  logic [7:0]  i_point_id,
    input  logic [15:0] i_touch_x,
    input  logic [15:0] i_touch_y,
    input  logic [15:0] i_tick_time,
    input  logic        i_group_busy,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_gesture,
    output logic        o_item_used,
    output logic        o_claim_group,
    output logic        o_release_group,
    output logic [15:0] o_pos_x,
    output logic [15:0] o_pos_y,
    output logic [16:0] o_move_x,
    output logic [16:0] o_move_y,
    output logic [15:0] o_pinch_ratio,
    output logic [15:0] o_rotation,
    output logic [31:0] o_held_time,
    output logic        o_last
);
    import tgr_pkg::*;

    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [2:0] reg_idx;
    logic       f_valid, f_pop;
    t_item      f_item;
    t_res       res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (reg_idx)
            REG_MASK:   prdata = {27'd0, r_cfg.mask};
            REG_DBL:    prdata = {31'd0, r_cfg.dbl};
            REG_LONG:   prdata = {31'd0, r_cfg.lt};
            REG_THR:    prdata = {24'd0, r_cfg.thr};
            REG_WINDOW: prdata = {16'd0, r_cfg.win};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mask <= '0;
            r_cfg.dbl  <= 1'b0;
            r_cfg.lt   <= 1'b0;
            r_cfg.thr  <= THR_RST;
            r_cfg.win  <= WINDOW_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MASK:   r_cfg.mask <= pwdata[4:0];
                REG_DBL:    r_cfg.dbl  <= pwdata[0];
                REG_LONG:   r_cfg.lt   <= pwdata[0];
                REG_THR:    r_cfg.thr  <= pwdata[7:0];
                REG_WINDOW: r_cfg.win  <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    tgr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_req_type   (i_req_type),
        .i_point_id   (i_point_id),
        .i_touch_x    (i_touch_x),
        .i_touch_y    (i_touch_y),
        .i_tick_time  (i_tick_time),
        .i_group_busy (i_group_busy),
        .o_valid      (f_valid),
        .o_item       (f_item),
        .i_pop        (f_pop)
    );

    tgr_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (f_valid),
        .i_item       (f_item),
        .o_item_pop   (f_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_res        (res)
    );

    assign o_gesture       = res.gesture;
    assign o_item_used     = res.used;
    assign o_claim_group   = res.claim;
    assign o_release_group = res.rel;
    assign o_pos_x         = res.pos_x;
    assign o_pos_y         = res.pos_y;
    assign o_move_x        = res.move_x;
    assign o_move_y        = res.move_y;
    assign o_pinch_ratio   = res.ratio;
    assign o_rotation      = res.rot;
    assign o_held_time     = res.held;
    assign o_last          = res.last;

    `TGR_ASSERT_NOW(a_claim_rel, !empty, !(o_claim_group && o_release_group), "claim and release together")
    `TGR_ASSERT_NOW(a_move_drag, !empty && o_gesture != G_DRAG, o_move_x == 17'd0 && o_move_y == 17'd0, "move offset outside drag")
    `TGR_ASSERT_NOW(a_held_long, !empty && o_gesture != G_LONG, o_held_time == 32'd0, "held time outside long tap")
    `TGR_ASSERT_NEXT(a_cfg_thr, cfg_wr && reg_idx == REG_THR, r_cfg.thr == $past(pwdata[7:0]), "threshold write lost")

endmodule

FILE: sv/tgr_front.sv
// front end: accepts touch items, classifies them and queues two deep
// depends on tgr_pkg
module tgr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  logic [2:0]    i_req_type,
    input  logic [7:0]    i_point_id,
    input  logic [15:0]   i_touch_x,
    input  logic [15:0]   i_touch_y,
    input  logic [15:0]   i_tick_time,
    input  logic          i_group_busy,
    output logic          o_valid,
    output tgr_pkg::t_item o_item,
    input  logic          i_pop
);
    import tgr_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      cls;
    logic       wr, rd;

    always_comb begin
        cls          = '0;
        cls.is_tap   = (i_req_type == REQ_TAP);
        cls.is_drag  = (i_req_type == REQ_DRAG);
        cls.is_end   = (i_req_type == REQ_RELEASE) || (i_req_type == REQ_CANCEL);
        cls.is_tick  = (i_req_type == REQ_TICK);
        cls.is_modal = (i_req_type == REQ_MODAL);
        cls.id       = i_point_id;
        cls.x        = i_touch_x;
        cls.y        = i_touch_y;
        cls.dt       = i_tick_time;
        cls.busy     = i_group_busy;
    end

    assign full    = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign wr      = push && !full;
    assign rd      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_q[r_wp] <= cls;
    end

endmodule

FILE: sv/tgr_cordic.sv
// vectoring cordic: length and angle of (dx, dy), one rotation per cycle
// depends on tgr_pkg
module tgr_cordic #(
    parameter int CORDIC_STEPS = tgr_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [16:0] i_dx,
    input  logic [16:0] i_dy,
    output logic        o_done,
    output logic [17:0] o_len,
    output logic [15:0] o_ang
);
    import tgr_pkg::*;

    localparam int SW = $clog2(CORDIC_STEPS);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_ITER = 4'b0010,
        C_MUL  = 4'b0100,
        C_OUT  = 4'b1000
    } t_cst;

    t_cst                 r_st, n_st;
    logic signed [CW-1:0] r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0] r_z, n_z, r_base, n_base;
    logic [SW-1:0]        r_i, n_i;
    logic [42:0]          r_prod, n_prod;
    logic [15:0]          r_ang, n_ang;

    logic signed [CW-1:0] x0, y0, xs, ys;
    logic signed [ZW-1:0] zb;
    logic [26:0]          xc;
    logic [43:0]          rnd;

    always_comb begin
        n_st   = r_st;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_base = r_base;
        n_i    = r_i;
        n_prod = r_prod;
        n_ang  = r_ang;
        x0     = $signed({{(CW-25){i_dx[16]}}, i_dx, 8'd0});
        y0     = $signed({{(CW-25){i_dy[16]}}, i_dy, 8'd0});
        xs     = r_x >>> r_i;
        ys     = r_y >>> r_i;
        zb     = r_z + r_base;
        if (zb < 0) zb = zb + TWO_PI_Q16;
        if (zb >= TWO_PI_Q16) zb = zb - TWO_PI_Q16;
        xc     = r_x[CW-1] ? 27'd0 : r_x[26:0];
        case (r_st)
            C_IDLE: begin
                if (i_start) begin
                    n_z  = '0;
                    n_i  = '0;
                    if (i_dx == 17'd0 && i_dy == 17'd0) begin
                        // coincident points: no rotation, length and angle zero
                        n_x    = '0;
                        n_y    = '0;
                        n_base = '0;
                        n_st   = C_MUL;
                    end else begin
                        n_x    = i_dx[16] ? -x0 : x0;
                        n_y    = i_dx[16] ? -y0 : y0;
                        n_base = i_dx[16] ? PI_Q16 : '0;
                        n_st   = C_ITER;
                    end
                end
            end
            C_ITER: begin
                if (!r_y[CW-1]) begin
                    n_x = r_x + ys;
                    n_y = r_y - xs;
                    n_z = r_z + atan_q16(5'(r_i));
                end else begin
                    n_x = r_x - ys;
                    n_y = r_y + xs;
                    n_z = r_z - atan_q16(5'(r_i));
                end
                n_i = r_i + 1'b1;
                if (r_i == SW'(CORDIC_STEPS - 1)) n_st = C_MUL;
            end
            C_MUL: begin
                n_prod = xc * INV_GAIN;
                n_ang  = 16'((20'(zb) + 20'd8) >> 4);
                n_st   = C_OUT;
            end
            C_OUT: begin
                n_st = C_IDLE;
            end
            default: n_st = C_IDLE;
        endcase
    end

    always_comb begin
        rnd    = {1'b0, r_prod} + 44'h0000_0800_000;
        o_len  = (rnd[43:24] > 20'd262143) ? 18'h3FFFF : rnd[41:24];
        o_ang  = r_ang;
        o_done = (r_st == C_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= C_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_base <= n_base;
        r_i    <= n_i;
        r_prod <= n_prod;
        r_ang  <= n_ang;
    end

endmodule

FILE: sv/tgr_div.sv
// restoring divider for the pinch ratio, one quotient bit per cycle
// depends on tgr_pkg
module tgr_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [26:0] i_num,
    input  logic [17:0] i_den,
    output logic        o_done,
    output logic [15:0] o_ratio
);
    import tgr_pkg::*;

    logic          r_busy;
    logic [4:0]    r_n;
    logic [18:0]   r_rem;
    logic [NW-1:0] r_q;
    logic [17:0]   r_den;
    logic [18:0]   rem2;
    logic          qb;

    always_comb begin
        rem2 = {r_rem[17:0], r_q[NW-1]};
        qb   = (rem2 >= {1'b0, r_den});
        if (qb) rem2 = rem2 - {1'b0, r_den};
    end

    assign o_done  = r_busy && (r_n == 5'(NW - 1));
    assign o_ratio = (|r_q[NW-2:15]) ? 16'hFFFF : {r_q[14:0], qb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= '0;
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_n   <= r_n + 5'd1;
            r_rem <= rem2;
            r_q   <= {r_q[NW-2:0], qb};
        end
    end

endmodule

FILE: sv/tgr_back.sv
// back end: gesture state, sequencer over cordic and divider, result queue
// depends on tgr_pkg, tgr_cordic, tgr_div
module tgr_back #(
    parameter int CORDIC_STEPS = tgr_pkg::CORDIC_STEPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tgr_pkg::t_cfg  i_cfg,
    input  logic           i_item_valid,
    input  tgr_pkg::t_item i_item,
    output logic           o_item_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output tgr_pkg::t_res  o_res
);
    import tgr_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_CST   = 7'b0000100,
        S_CORD  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_EMIT2 = 7'b1000000
    } t_st;

    t_st         r_st, n_st;
    t_item       r_item, n_item;
    logic        r_ctl, n_ctl;
    logic [1:0]  r_cnt, n_cnt;
    logic [7:0]  r_ids [2];
    logic [7:0]  n_ids [2];
    logic        r_moved [2];
    logic        n_moved [2];
    logic [15:0] r_px [2];
    logic [15:0] n_px [2];
    logic [15:0] r_py [2];
    logic [15:0] n_py [2];
    logic [15:0] r_tap_x, n_tap_x, r_tap_y, n_tap_y;
    logic [16:0] r_exc_x, n_exc_x, r_exc_y, n_exc_y;
    logic [17:0] r_slen, n_slen;
    logic [15:0] r_sang, n_sang;
    logic [31:0] r_hold, n_hold;
    logic        r_pend, n_pend;
    logic [16:0] r_timer, n_timer;
    logic [15:0] r_ck_x, n_ck_x, r_ck_y, n_ck_y;
    logic        r_ctf, n_ctf;
    t_res        r_res0, n_res0, r_res1, n_res1;
    logic        r_two, n_two;
    logic        r_tapm, n_tapm;

    t_res        r_oq [4];
    logic [1:0]  r_owp, r_orp;
    logic [2:0]  r_ocnt;
    logic        opush, opop;
    t_res        opay;

    logic        c_start, c_done, d_start, d_done;
    logic [17:0] c_len;
    logic [15:0] c_ang, d_ratio;
    logic [26:0] d_num;
    logic [16:0] c_dx, c_dy;

    logic               pos0, pos1, found, pidx, ix, meas, gate_lt, lt_fire, ct_fire;
    logic signed [16:0] mx, my, rx, ry;
    logic [16:0]        ax, ay, exx, exy, thr17, tsat;
    logic [32:0]        hsum;
    logic [17:0]        tsum;
    t_res               lt_res, ct_res;

    assign c_dx = 17'({r_px[1][15], r_px[1]} - {r_px[0][15], r_px[0]});
    assign c_dy = 17'({r_py[1][15], r_py[1]} - {r_py[0][15], r_py[0]});
    assign d_num = {1'b0, c_len, 8'd0} + {10'd0, r_slen[17:1]};

    tgr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_dx    (c_dx),
        .i_dy    (c_dy),
        .o_done  (c_done),
        .o_len   (c_len),
        .o_ang   (c_ang)
    );

    tgr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (d_start),
        .i_num   (d_num),
        .i_den   (r_slen),
        .o_done  (d_done),
        .o_ratio (d_ratio)
    );

    always_comb begin
        n_st    = r_st;
        n_item  = r_item;
        n_ctl   = r_ctl;
        n_cnt   = r_cnt;
        n_ids   = r_ids;
        n_moved = r_moved;
        n_px    = r_px;
        n_py    = r_py;
        n_tap_x = r_tap_x;
        n_tap_y = r_tap_y;
        n_exc_x = r_exc_x;
        n_exc_y = r_exc_y;
        n_slen  = r_slen;
        n_sang  = r_sang;
        n_hold  = r_hold;
        n_pend  = r_pend;
        n_timer = r_timer;
        n_ck_x  = r_ck_x;
        n_ck_y  = r_ck_y;
        n_ctf   = r_ctf;
        n_res0  = r_res0;
        n_res1  = r_res1;
        n_two   = r_two;
        n_tapm  = r_tapm;
        o_item_pop = 1'b0;
        c_start = 1'b0;
        d_start = 1'b0;
        opush   = 1'b0;
        opay    = r_res0;
        meas    = 1'b0;
        lt_res  = '0;
        ct_res  = '0;
        lt_fire = 1'b0;
        ct_fire = 1'b0;

        pos1  = (r_cnt == 2'd2) && (r_ids[1] == r_item.id);
        pos0  = (r_cnt != 2'd0) && (r_ids[0] == r_item.id);
        found = pos0 || pos1;
        pidx  = pos1;
        ix    = r_cnt[0];
        mx    = $signed({r_item.x[15], r_item.x}) - $signed({r_tap_x[15], r_tap_x});
        my    = $signed({r_item.y[15], r_item.y}) - $signed({r_tap_y[15], r_tap_y});
        rx    = -mx;
        ry    = -my;
        ax    = mx[16] ? rx : mx;
        ay    = my[16] ? ry : my;
        exx   = (ax > r_exc_x) ? ax : r_exc_x;
        exy   = (ay > r_exc_y) ? ay : r_exc_y;
        thr17 = {9'd0, i_cfg.thr};
        hsum  = {1'b0, r_hold} + {17'd0, r_item.dt};
        tsum  = {1'b0, r_timer} + {2'd0, r_item.dt};
        tsat  = tsum[17] ? 17'h1FFFF : tsum[16:0];
        gate_lt = i_cfg.lt && !r_item.busy && !i_cfg.mask[MB_LONG];

        case (r_st)
            S_IDLE: begin
                // room for two results before an item is taken
                if (i_item_valid && r_ocnt <= 3'd2) begin
                    o_item_pop = 1'b1;
                    n_item     = i_item;
                    n_st       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res0 = '0;
                n_res1 = '0;
                n_two  = 1'b0;
                n_tapm = 1'b0;
                if (r_item.is_tap) begin
                    if (r_cnt < 2'd2 && !(r_cnt == 2'd0 && r_item.busy)) begin
                        n_res0.claim = 1'b1;
                        n_res0.used  = 1'b1;
                        n_ids[ix]    = r_item.id;
                        n_moved[ix]  = 1'b0;
                        n_px[ix]     = r_item.x;
                        n_py[ix]     = r_item.y;
                        if (r_cnt == 2'd0) begin
                            n_hold  = '0;
                            n_tap_x = r_item.x;
                            n_tap_y = r_item.y;
                            n_exc_x = '0;
                            n_exc_y = '0;
                        end else begin
                            meas   = 1'b1;
                            n_tapm = 1'b1;
                        end
                        n_cnt = r_cnt + 2'd1;
                        n_ctl = 1'b1;
                    end
                end else if (r_item.is_drag) begin
                    if (r_ctl && found && r_cnt == 2'd1) begin
                        n_exc_x     = exx;
                        n_exc_y     = exy;
                        n_res0.used = 1'b1;
                        if (exx >= thr17 || exy >= thr17) begin
                            n_moved[pidx] = 1'b1;
                            if (!r_item.busy && !i_cfg.mask[MB_DRAG]) begin
                                n_res0.gesture = G_DRAG;
                                n_res0.pos_x   = r_item.x;
                                n_res0.pos_y   = r_item.y;
                                n_res0.move_x  = mx;
                                n_res0.move_y  = my;
                            end
                        end
                    end else if (r_ctl && found && r_cnt == 2'd2) begin
                        n_px[pidx]  = r_item.x;
                        n_py[pidx]  = r_item.y;
                        n_res0.used = 1'b1;
                        if (!r_item.busy && !i_cfg.mask[MB_PINCH]) begin
                            n_res0.gesture = G_PINCH;
                            meas           = 1'b1;
                        end
                    end
                end else if (r_item.is_end) begin
                    if (r_ctl) begin
                        if (r_cnt == 2'd1) begin
                            if (r_ids[0] == r_item.id) begin
                                n_res0.used = 1'b1;
                                n_ctl = 1'b0;
                                n_cnt = 2'd0;
                                if (r_exc_x < thr17 && r_exc_y < thr17) begin
                                    if (!r_pend) begin
                                        n_pend  = 1'b1;
                                        n_timer = '0;
                                        n_ck_x  = r_tap_x;
                                        n_ck_y  = r_tap_y;
                                    end else if (r_timer < {1'b0, i_cfg.win}) begin
                                        // second click inside the window
                                        n_pend  = 1'b0;
                                        n_timer = '0;
                                        if (i_cfg.dbl) begin
                                            if (!r_item.busy && !i_cfg.mask[MB_DBL])
                                                n_res0.gesture = G_DBL;
                                        end else if (!r_item.busy && !i_cfg.mask[MB_CLICK]
                                                     && !r_ctf) begin
                                            n_ctf          = 1'b1;
                                            n_res0.gesture = G_CLICK;
                                        end
                                        if (n_res0.gesture != G_NONE) begin
                                            n_res0.pos_x = r_ck_x;
                                            n_res0.pos_y = r_ck_y;
                                        end
                                        n_res0.rel = 1'b1;
                                    end
                                end else if (!r_item.busy && !i_cfg.mask[MB_DRAG]) begin
                                    n_res0.gesture = G_DRAG;
                                    n_res0.pos_x   = r_item.x;
                                    n_res0.pos_y   = r_item.y;
                                    n_res0.move_x  = mx;
                                    n_res0.move_y  = my;
                                    n_res0.rel     = 1'b1;
                                end
                            end
                        end else if (r_cnt == 2'd2) begin
                            if (found) begin
                                n_px[pidx]  = r_item.x;
                                n_py[pidx]  = r_item.y;
                                n_res0.used = 1'b1;
                                n_res0.rel  = 1'b1;
                                n_ctl       = 1'b0;
                                n_cnt       = 2'd0;
                                if (!r_item.busy && !i_cfg.mask[MB_PINCH]) begin
                                    n_res0.gesture = G_PINCH;
                                    meas           = 1'b1;
                                end
                            end
                        end else begin
                            n_ctl = 1'b0;
                            n_cnt = 2'd0;
                        end
                    end
                end else if (r_item.is_tick) begin
                    if (r_cnt == 2'd1 && !r_moved[0]) begin
                        if (r_hold != 32'd0 && gate_lt) begin
                            lt_fire        = 1'b1;
                            lt_res.gesture = G_LONG;
                            lt_res.pos_x   = r_tap_x;
                            lt_res.pos_y   = r_tap_y;
                            lt_res.held    = r_hold;
                            lt_res.rel     = 1'b1;
                        end
                        n_hold = hsum[32] ? 32'hFFFF_FFFF : hsum[31:0];
                    end
                    if (r_pend) begin
                        n_timer = tsat;
                        if (tsat >= {1'b0, i_cfg.win}) begin
                            n_timer    = '0;
                            n_pend     = 1'b0;
                            ct_fire    = 1'b1;
                            ct_res.rel = 1'b1;
                            if (!r_item.busy && !i_cfg.mask[MB_CLICK] && !r_ctf) begin
                                ct_res.gesture = G_CLICK;
                                ct_res.pos_x   = r_ck_x;
                                ct_res.pos_y   = r_ck_y;
                            end
                        end
                    end
                    // the one-click-per-frame limit resets at every tick
                    n_ctf  = 1'b0;
                    n_res0 = lt_fire ? lt_res : ct_res;
                    n_res1 = ct_res;
                    n_two  = lt_fire && ct_fire;
                end else if (r_item.is_modal) begin
                    n_ctl  = 1'b0;
                    n_cnt  = 2'd0;
                    n_pend = 1'b0;
                end
                n_st = meas ? S_CST : S_EMIT;
            end
            S_CST: begin
                c_start = 1'b1;
                n_st    = S_CORD;
            end
            S_CORD: begin
                if (c_done) begin
                    if (r_tapm) begin
                        n_slen = c_len;
                        n_sang = c_ang;
                        n_st   = S_EMIT;
                    end else begin
                        n_res0.rot = c_ang - r_sang;
                        if (r_slen == 18'd0) begin
                            n_res0.ratio = 16'hFFFF;
                            n_st         = S_EMIT;
                        end else begin
                            d_start = 1'b1;
                            n_st    = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                if (d_done) begin
                    n_res0.ratio = d_ratio;
                    n_st         = S_EMIT;
                end
            end
            S_EMIT: begin
                opush     = 1'b1;
                opay      = r_res0;
                opay.last = !r_two;
                n_st      = r_two ? S_EMIT2 : S_IDLE;
            end
            S_EMIT2: begin
                opush     = 1'b1;
                opay      = r_res1;
                opay.last = 1'b1;
                n_st      = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    assign o_empty = (r_ocnt == 3'd0);
    assign o_res   = r_oq[r_orp];
    assign opop    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= S_IDLE;
            r_ctl      <= 1'b0;
            r_cnt      <= 2'd0;
            r_moved[0] <= 1'b0;
            r_moved[1] <= 1'b0;
            r_exc_x    <= '0;
            r_exc_y    <= '0;
            r_hold     <= '0;
            r_pend     <= 1'b0;
            r_timer    <= '0;
            r_ctf      <= 1'b0;
            r_owp      <= '0;
            r_orp      <= '0;
            r_ocnt     <= '0;
        end else begin
            r_st    <= n_st;
            r_ctl   <= n_ctl;
            r_cnt   <= n_cnt;
            r_moved <= n_moved;
            r_exc_x <= n_exc_x;
            r_exc_y <= n_exc_y;
            r_hold  <= n_hold;
            r_pend  <= n_pend;
            r_timer <= n_timer;
            r_ctf   <= n_ctf;
            if (opush) r_owp <= r_owp + 2'd1;
            if (opop)  r_orp <= r_orp + 2'd1;
            r_ocnt  <= r_ocnt + {2'd0, opush} - {2'd0, opop};
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_ids   <= n_ids;
        r_px    <= n_px;
        r_py    <= n_py;
        r_tap_x <= n_tap_x;
        r_tap_y <= n_tap_y;
        r_slen  <= n_slen;
        r_sang  <= n_sang;
        r_ck_x  <= n_ck_x;
        r_ck_y  <= n_ck_y;
        r_res0  <= n_res0;
        r_res1  <= n_res1;
        r_two   <= n_two;
        r_tapm  <= n_tapm;
        if (opush) r_oq[r_owp] <= opay;
    end

endmodule
